// File: hdl/pmdi_pkg.sv
// ----------------------------------------------------------------------------
// pmdi_pkg
// Shared types and constants for the point-mass drag integrator: request
// codes, register indexes, sequencer states and the lane control bundle.
// ----------------------------------------------------------------------------
package pmdi_pkg;

  // request codes carried in req_type
  localparam logic [1:0] REQ_ADD_FORCE = 2'd0;
  localparam logic [1:0] REQ_STEP      = 2'd1;
  localparam logic [1:0] REQ_SET_VEL   = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_DRAG_COEFF = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_MASS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_ON = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REST_SPEED = 3'd4;

  // register reset values
  localparam logic [30:0] DRAG_COEFF_RST = 31'd0;
  localparam logic [30:0] INV_MASS_RST   = 31'd65536;
  localparam logic [30:0] GRAVITY_RST    = 31'd642908;
  localparam logic        GRAVITY_ON_RST = 1'b1;
  localparam logic [30:0] REST_SPEED_RST = 31'd32768;

  // drag magnitude clamp, 2^33
  localparam logic [33:0] DRAG_CAP = 34'h2_0000_0000;

  localparam int unsigned NUM_LANES = 3;

  // step sequencer states
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SQ    = 7'b0000010,
    ST_DRAG  = 7'b0000100,
    ST_FORCE = 7'b0001000,
    ST_ACC   = 7'b0010000,
    ST_KICK  = 7'b0100000,
    ST_DRIFT = 7'b1000000
  } step_state_t;

  // per-cycle strobes from the sequencer to the lanes and the merge stage
  typedef struct packed {
    logic add_force;
    logic set_vel;
    logic load_step;
    logic do_sq;
    logic do_drag;
    logic do_force;
    logic do_acc;
    logic do_kick;
    logic do_drift;
  } lane_ctrl_t;

endpackage

// File: hdl/pmdi_if.sv
// ----------------------------------------------------------------------------
// pmdi_in_if / pmdi_out_if
// Valid/ready channels for request items and step results.
// ----------------------------------------------------------------------------
interface pmdi_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic signed [31:0] vec_z;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [15:0]        time_step;

  modport source (
    output valid, req_type, vec_x, vec_y, vec_z, pos_x, pos_y, pos_z, time_step,
    input  ready
  );
  modport sink (
    input  valid, req_type, vec_x, vec_y, vec_z, pos_x, pos_y, pos_z, time_step,
    output ready
  );
endinterface

interface pmdi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_pos_x;
  logic signed [31:0] new_pos_y;
  logic signed [31:0] new_pos_z;
  logic signed [31:0] new_vel_x;
  logic signed [31:0] new_vel_y;
  logic signed [31:0] new_vel_z;

  modport source (
    output valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z,
    input  ready
  );
  modport sink (
    input  valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z,
    output ready
  );
endinterface

// File: hdl/pmdi_lane.sv
// ----------------------------------------------------------------------------
// pmdi_lane
// One axis of the integrator: holds the axis velocity and force, and runs
// the drag, acceleration, half-kick and drift chain as a sequence of registered steps.
// ----------------------------------------------------------------------------
module pmdi_lane import pmdi_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  lane_ctrl_t         ctrl,
  input  logic signed [31:0] vec_in,
  input  logic signed [31:0] pos_in,
  input  logic [15:0]        dt,
  input  logic [30:0]        drag_coeff,
  input  logic [30:0]        inv_mass,
  input  logic [30:0]        grav_sub,
  input  logic               snap,
  output logic [62:0]        speed_sq,
  output logic signed [31:0] new_pos,
  output logic signed [31:0] new_vel
);

  // clamp a wide signed value to 32 bits
  function automatic logic signed [31:0] sat49(input logic signed [48:0] x);
    logic same;
    same = (&x[48:31]) | (~|x[48:31]);
    if (same) return x[31:0];
    return x[48] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

  logic signed [31:0] vel_r, force_r, pos_r;
  logic [62:0]        sq_r;
  logic [61:0]        hi_prod_r;
  logic [30:0]        lo_prod_r;
  logic signed [31:0] f_r, a_r, dv_r, v1_r;

  logic [31:0]        mag;
  logic [63:0]        sq_full;
  logic [61:0]        hi_full;
  logic [46:0]        lo_full;
  logic [62:0]        drag_sum;
  logic [33:0]        dm;
  logic signed [35:0] drag_s;
  logic signed [48:0] f_diff;
  logic signed [63:0] acc_prod;
  logic signed [48:0] acc_sum;
  logic signed [48:0] kick_prod;
  logic signed [31:0] dv;
  logic signed [31:0] v_snap;
  logic signed [48:0] v1_sum;
  logic signed [48:0] drift_prod;
  logic signed [48:0] p_sum;
  logic signed [48:0] v2_sum;
  logic signed [48:0] fadd_sum;

  // speed squared and drag partial products
  always_comb begin
    mag      = vel_r[31] ? (~vel_r + 32'd1) : vel_r;
    sq_full  = mag * mag;
    hi_full  = sq_r[62:32] * drag_coeff;
    lo_full  = sq_r[31:16] * drag_coeff;
    drag_sum = {1'b0, hi_prod_r} + {32'd0, lo_prod_r};
    dm       = (drag_sum > {29'd0, DRAG_CAP}) ? DRAG_CAP : drag_sum[33:0];
    drag_s   = vel_r[31] ? -$signed({2'b00, dm}) : $signed({2'b00, dm});
    f_diff   = 49'(force_r) - 49'(drag_s);
  end

  // acceleration, half kick and drift
  always_comb begin
    acc_prod   = f_r * $signed({1'b0, inv_mass});
    acc_sum    = 49'($signed(acc_prod[63:16])) - 49'($signed({1'b0, grav_sub}));
    kick_prod  = a_r * $signed({1'b0, dt});
    dv         = kick_prod[48:17];
    v_snap     = snap ? 32'sd0 : vel_r;
    v1_sum     = 49'(v_snap) + 49'(dv);
    drift_prod = v1_r * $signed({1'b0, dt});
    p_sum      = 49'(pos_r) + 49'($signed(drift_prod[48:16]));
    v2_sum     = 49'(v1_r) + 49'(dv_r);
    fadd_sum   = 49'(force_r) + 49'(vec_in);
  end

  assign new_pos  = sat49(p_sum);
  assign new_vel  = sat49(v2_sum);
  assign speed_sq = sq_r;

  // axis state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vel_r   <= '0;
      force_r <= '0;
    end else begin
      if (ctrl.add_force) begin
        force_r <= sat49(fadd_sum);
      end else if (ctrl.do_drift) begin
        force_r <= '0;
      end
      if (ctrl.set_vel) begin
        vel_r <= vec_in;
      end else if (ctrl.do_drift) begin
        vel_r <= new_vel;
      end
    end
  end

  // step datapath registers
  always_ff @(posedge clk) begin
    if (ctrl.load_step) pos_r <= pos_in;
    if (ctrl.do_sq) sq_r <= sq_full[62:0];
    if (ctrl.do_drag) begin
      hi_prod_r <= hi_full;
      lo_prod_r <= lo_full[46:16];
    end
    if (ctrl.do_force) f_r <= sat49(f_diff);
    if (ctrl.do_acc) a_r <= sat49(acc_sum);
    if (ctrl.do_kick) begin
      dv_r <= dv;
      v1_r <= sat49(v1_sum);
    end
  end

endmodule

// File: hdl/pmdi_merge.sv
// ----------------------------------------------------------------------------
// pmdi_merge
// Combines the lanes: sums the squared speeds for the rest test and holds
// the finished step result in the output register.
// ----------------------------------------------------------------------------
module pmdi_merge import pmdi_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lane_ctrl_t                 ctrl,
  input  logic [30:0]                rest_speed,
  input  logic [NUM_LANES-1:0][62:0] lane_sq,
  input  logic [NUM_LANES-1:0][31:0] lane_pos,
  input  logic [NUM_LANES-1:0][31:0] lane_vel,
  input  logic                       out_ready,
  output logic                       snap,
  output logic                       out_free,
  output logic                       out_valid,
  output logic [NUM_LANES-1:0][31:0] out_pos,
  output logic [NUM_LANES-1:0][31:0] out_vel
);

  logic [61:0] rest_sq_r;
  logic [63:0] speed_sq_r;
  logic        snap_r;
  logic        out_valid_r;
  logic [NUM_LANES-1:0][31:0] out_pos_r, out_vel_r;
  logic [63:0] speed_sum;

  // sum of squared axis speeds
  always_comb begin
    speed_sum = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      speed_sum = speed_sum + {1'b0, lane_sq[i]};
    end
  end

  // rest test
  always_ff @(posedge clk) begin
    if (ctrl.do_sq) rest_sq_r <= rest_speed * rest_speed;
    if (ctrl.do_drag) speed_sq_r <= speed_sum;
    if (ctrl.do_force) snap_r <= (speed_sq_r < {2'b00, rest_sq_r});
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.do_drift) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.do_drift) begin
      out_pos_r <= lane_pos;
      out_vel_r <= lane_vel;
    end
  end

  assign snap      = snap_r;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_pos   = out_pos_r;
  assign out_vel   = out_vel_r;

endmodule

// File: hdl/point_mass_drag_integrator_top.sv
// ----------------------------------------------------------------------------
// point_mass_drag_integrator_top
// Three-axis point-mass integrator with quadratic drag in Q16.16.
// ----------------------------------------------------------------------------
// add-force and set-velocity transfers are taken back to back
// a step runs through the lane chain (speed squared, drag, force, acceleration,
// half kick, drift); the result register is loaded in the drift state
// the next item can be taken in the cycle after the result is loaded; none during a step
// a stalled result register holds the step in its drift cycle
// synchronous active-low reset clears velocity, force and config to defaults
module point_mass_drag_integrator_top import pmdi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  pmdi_in_if.sink              in_ch,
  pmdi_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [30:0]          cfg_data
);

  step_state_t state_r, state_nxt;
  lane_ctrl_t  ctrl;

  logic [30:0] drag_coeff_r, inv_mass_r, gravity_r, rest_speed_r;
  logic        gravity_on_r;
  logic [15:0] dt_r;
  logic        in_xfer;
  logic        snap, out_free;

  logic [NUM_LANES-1:0][31:0] lane_vec, lane_pos_in;
  logic [NUM_LANES-1:0][30:0] lane_grav;
  logic [NUM_LANES-1:0][62:0] lane_sq;
  logic [NUM_LANES-1:0][31:0] lane_pos, lane_vel;
  logic [NUM_LANES-1:0][31:0] out_pos, out_vel;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drag_coeff_r <= DRAG_COEFF_RST;
      inv_mass_r   <= INV_MASS_RST;
      gravity_r    <= GRAVITY_RST;
      gravity_on_r <= GRAVITY_ON_RST;
      rest_speed_r <= REST_SPEED_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_DRAG_COEFF: drag_coeff_r <= cfg_data;
        CFG_INV_MASS:   inv_mass_r   <= cfg_data;
        CFG_GRAVITY:    gravity_r    <= cfg_data;
        CFG_GRAVITY_ON: gravity_on_r <= cfg_data[0];
        CFG_REST_SPEED: rest_speed_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // input transfer
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // step sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_xfer && in_ch.req_type == REQ_STEP) state_nxt = ST_SQ;
      ST_SQ:    state_nxt = ST_DRAG;
      ST_DRAG:  state_nxt = ST_FORCE;
      ST_FORCE: state_nxt = ST_ACC;
      ST_ACC:   state_nxt = ST_KICK;
      ST_KICK:  state_nxt = ST_DRIFT;
      ST_DRIFT: if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_step) dt_r <= in_ch.time_step;
  end

  // strobes to lanes and merge stage
  always_comb begin
    ctrl.add_force = in_xfer && (in_ch.req_type == REQ_ADD_FORCE);
    ctrl.set_vel   = in_xfer && (in_ch.req_type == REQ_SET_VEL);
    ctrl.load_step = in_xfer && (in_ch.req_type == REQ_STEP);
    ctrl.do_sq     = (state_r == ST_SQ);
    ctrl.do_drag   = (state_r == ST_DRAG);
    ctrl.do_force  = (state_r == ST_FORCE);
    ctrl.do_acc    = (state_r == ST_ACC);
    ctrl.do_kick   = (state_r == ST_KICK);
    ctrl.do_drift  = (state_r == ST_DRIFT) && out_free;
  end

  // per-axis operands; gravity pulls on y only
  assign lane_vec    = {in_ch.vec_z, in_ch.vec_y, in_ch.vec_x};
  assign lane_pos_in = {in_ch.pos_z, in_ch.pos_y, in_ch.pos_x};
  assign lane_grav   = {31'd0, (gravity_on_r ? gravity_r : 31'd0), 31'd0};

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    pmdi_lane u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .vec_in     ($signed(lane_vec[g])),
      .pos_in     ($signed(lane_pos_in[g])),
      .dt         (dt_r),
      .drag_coeff (drag_coeff_r),
      .inv_mass   (inv_mass_r),
      .grav_sub   (lane_grav[g]),
      .snap       (snap),
      .speed_sq   (lane_sq[g]),
      .new_pos    (lane_pos[g]),
      .new_vel    (lane_vel[g])
    );
  end

  pmdi_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .rest_speed (rest_speed_r),
    .lane_sq    (lane_sq),
    .lane_pos   (lane_pos),
    .lane_vel   (lane_vel),
    .out_ready  (out_ch.ready),
    .snap       (snap),
    .out_free   (out_free),
    .out_valid  (out_ch.valid),
    .out_pos    (out_pos),
    .out_vel    (out_vel)
  );

  // result payload
  assign out_ch.new_pos_x = out_pos[0];
  assign out_ch.new_pos_y = out_pos[1];
  assign out_ch.new_pos_z = out_pos[2];
  assign out_ch.new_vel_x = out_vel[0];
  assign out_ch.new_vel_y = out_vel[1];
  assign out_ch.new_vel_z = out_vel[2];

endmodule

// File: hdl/pmdi_checker.sv
// ----------------------------------------------------------------------------
// pmdi_checker
// Port-level checks on the integrator: result holding, reset, and the
// relation between step transfers and input readiness.
// ----------------------------------------------------------------------------
module pmdi_checker import pmdi_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  req_type,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] new_pos_x,
  input logic [31:0] new_vel_y
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(new_pos_x) && $stable(new_vel_y))
    else $error("result changed while stalled");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a step transfer blocks the input while it runs
  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && req_type == REQ_STEP |=> !in_ready)
    else $error("input ready during step");

  // other requests leave the input ready in the next cycle
  a_other_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && req_type != REQ_STEP |=> in_ready)
    else $error("input blocked after non-step request");

  // a new result only comes out of a running step
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without a step in flight");

endmodule

bind point_mass_drag_integrator_top pmdi_checker u_pmdi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .req_type  (in_ch.req_type),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .new_pos_x (out_ch.new_pos_x),
  .new_vel_y (out_ch.new_vel_y)
);
